// ----- sv/c12cf_pkg.sv -----
// ----------------------------------------------------------------------------
// c12cf_pkg
// Types, codes and helpers shared by the codec-12 command framer.
// ----------------------------------------------------------------------------
package c12cf_pkg;

	// Operation codes of an input transaction.
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_BYTE  = 2'd1;
	localparam logic [1:0] OP_END   = 2'd2;

	// Fixed bytes of the frame.
	localparam logic [7:0] CODEC_ID     = 8'h0C;
	localparam logic [7:0] CMD_COUNT    = 8'h01;
	localparam logic [7:0] CMD_TYPE     = 8'h05;
	localparam logic [7:0] CHAR_CR      = 8'h0D;
	localparam logic [7:0] CHAR_LF      = 8'h0A;
	localparam logic [7:0] CMD_COUNT_2  = 8'h01;

	// Header length adders.
	localparam logic [16:0] DATA_LEN_ADD = 17'd10;
	localparam logic [16:0] CMD_SIZE_ADD = 17'd2;

	// CRC-16/ARC parameters.
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_INIT = 16'h0000;

	// Byte positions within one transaction's output.
	localparam logic [3:0] IDX_FIRST      = 4'd0;
	localparam logic [3:0] HDR_CRC_FIRST  = 4'd8;
	localparam logic [3:0] HDR_LAST       = 4'd14;
	localparam logic [3:0] TRL_CRC_LAST   = 4'd2;
	localparam logic [3:0] TRL_LAST       = 4'd6;

	// Input transaction payload.
	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] cmd_len;
		logic [7:0]  cmd_byte;
	} item_t;

	// Output transaction payload.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} frame_t;

	// One byte step of the reflected CRC-16/ARC.
	function automatic logic [15:0] crc16_arc_byte(input logic [15:0] crc_in,
	                                               input logic [7:0]  data);
		logic [15:0] crc;
		crc = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (crc[0]) begin
				crc = (crc >> 1) ^ CRC_POLY;
			end else begin
				crc = crc >> 1;
			end
		end
		return crc;
	endfunction

endpackage

// ----- sv/codec12_command_framer_top.sv -----
// ----------------------------------------------------------------------------
// codec12_command_framer_top
// Frames a text command into a codec-12 command packet, one byte per output
// transaction, with a running CRC-16/ARC.
// ----------------------------------------------------------------------------
// The block emits one packet byte per clock while the consumer keeps
// frame_ready high. A command-byte transaction produces a single byte, so
// command bytes stream at full rate; a start transaction holds the byte
// sequencer for its 15 bytes and an end transaction for its 7. Transactions
// that produce nothing (a byte or end outside a packet, or an unused op
// code) are dropped at acceptance. Back-to-back streaming rests on the
// single output byte register: the next transaction is accepted in the
// same cycle as the final byte of the current one moves into it.
module codec12_command_framer_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  c12cf_pkg::item_t    item,
	output logic                frame_valid,
	input  logic                frame_ready,
	output c12cf_pkg::frame_t   frame
);

	logic              valid_s1;
	logic [1:0]        op_s1;
	logic [16:0]       total_s1;
	logic [16:0]       csz_s1;
	logic [7:0]        byte_s1;
	logic [3:0]        idx_q;
	logic              in_packet_q;
	logic [15:0]       crc_q;
	logic              frame_valid_q;
	c12cf_pkg::frame_t frame_q;

	logic              item_accept;
	logic              item_ignore;
	logic              advance;
	logic              final_byte;
	logic              fold;
	logic [7:0]        next_byte;

	// Transactions that produce no bytes are dropped at the input.
	assign item_ignore = (item.op == c12cf_pkg::OP_BYTE && !in_packet_q) ||
	                     (item.op == c12cf_pkg::OP_END && !in_packet_q) ||
	                     !(item.op inside {c12cf_pkg::OP_START, c12cf_pkg::OP_BYTE,
	                                       c12cf_pkg::OP_END});

	// The sequencer moves one byte when the output register is free or drains.
	assign advance     = valid_s1 && (!frame_valid_q || frame_ready);
	assign item_ready  = !valid_s1 || (advance && final_byte);
	assign item_accept = item_valid && item_ready;

	// Byte selection for the current position of the held transaction.
	always_comb begin
		next_byte  = 8'h00;
		fold       = 1'b0;
		final_byte = 1'b0;
		case (op_s1)
			c12cf_pkg::OP_START: begin
				fold       = (idx_q >= c12cf_pkg::HDR_CRC_FIRST);
				final_byte = (idx_q == c12cf_pkg::HDR_LAST);
				case (idx_q)
					4'd5:    next_byte = {7'd0, total_s1[16]};
					4'd6:    next_byte = total_s1[15:8];
					4'd7:    next_byte = total_s1[7:0];
					4'd8:    next_byte = c12cf_pkg::CODEC_ID;
					4'd9:    next_byte = c12cf_pkg::CMD_COUNT;
					4'd10:   next_byte = c12cf_pkg::CMD_TYPE;
					4'd12:   next_byte = {7'd0, csz_s1[16]};
					4'd13:   next_byte = csz_s1[15:8];
					4'd14:   next_byte = csz_s1[7:0];
					default: next_byte = 8'h00;
				endcase
			end
			c12cf_pkg::OP_BYTE: begin
				next_byte  = byte_s1;
				fold       = 1'b1;
				final_byte = 1'b1;
			end
			c12cf_pkg::OP_END: begin
				fold       = (idx_q <= c12cf_pkg::TRL_CRC_LAST);
				final_byte = (idx_q == c12cf_pkg::TRL_LAST);
				case (idx_q)
					4'd0:    next_byte = c12cf_pkg::CHAR_CR;
					4'd1:    next_byte = c12cf_pkg::CHAR_LF;
					4'd2:    next_byte = c12cf_pkg::CMD_COUNT_2;
					4'd5:    next_byte = crc_q[15:8];
					4'd6:    next_byte = crc_q[7:0];
					default: next_byte = 8'h00;
				endcase
			end
			default: begin
				next_byte  = 8'h00;
				fold       = 1'b0;
				final_byte = 1'b1;
			end
		endcase
	end

	// Control of the held transaction, its byte position and packet state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			idx_q       <= c12cf_pkg::IDX_FIRST;
			in_packet_q <= 1'b0;
		end else begin
			if (item_accept) begin
				valid_s1 <= !item_ignore;
			end else if (advance && final_byte) begin
				valid_s1 <= 1'b0;
			end
			if (item_accept || (advance && final_byte)) begin
				idx_q <= c12cf_pkg::IDX_FIRST;
			end else if (advance) begin
				idx_q <= idx_q + 4'd1;
			end
			if (item_accept && item.op == c12cf_pkg::OP_START) begin
				in_packet_q <= 1'b1;
			end else if (item_accept && item.op == c12cf_pkg::OP_END) begin
				in_packet_q <= 1'b0;
			end
		end
	end

	// Payload of the held transaction, with the header lengths precomputed.
	always_ff @(posedge clk) begin
		if (item_accept) begin
			op_s1    <= item.op;
			total_s1 <= {1'b0, item.cmd_len} + c12cf_pkg::DATA_LEN_ADD;
			csz_s1   <= {1'b0, item.cmd_len} + c12cf_pkg::CMD_SIZE_ADD;
			byte_s1  <= item.cmd_byte;
		end
	end

	// Running CRC, cleared by the first byte of a start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= c12cf_pkg::CRC_INIT;
		end else if (advance) begin
			if (op_s1 == c12cf_pkg::OP_START && idx_q == c12cf_pkg::IDX_FIRST) begin
				crc_q <= c12cf_pkg::CRC_INIT;
			end else if (fold) begin
				crc_q <= c12cf_pkg::crc16_arc_byte(crc_q, next_byte);
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q <= 1'b0;
		end else if (advance) begin
			frame_valid_q <= 1'b1;
		end else if (frame_ready) begin
			frame_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			frame_q.out_byte <= next_byte;
			frame_q.last     <= (op_s1 == c12cf_pkg::OP_END) && final_byte;
		end
	end

	assign frame_valid = frame_valid_q;
	assign frame       = frame_q;

`ifndef SYNTHESIS
	// A start always restarts the CRC from its initial value.
	a_crc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 == c12cf_pkg::OP_START && idx_q == c12cf_pkg::IDX_FIRST
		|=> crc_q == c12cf_pkg::CRC_INIT)
		else $error("CRC not cleared at start of packet");

	// A byte waiting in the output register is not overwritten.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid_q && !frame_ready |=> frame_valid_q && $stable(frame_q))
		else $error("output byte changed while stalled");

	// The byte position never runs past the longest sequence.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> idx_q <= c12cf_pkg::HDR_LAST)
		else $error("byte position out of range");

	// An end transaction marks its byte last only at its final slot (checked while the output register is empty).
	a_last_slot: assert property (@(posedge clk) disable iff (!arst_n)
		advance && frame_valid_q == 1'b0 && final_byte && op_s1 == c12cf_pkg::OP_END
		|-> idx_q == c12cf_pkg::TRL_LAST)
		else $error("last marker at wrong position");
`endif

endmodule
